/* rtl/ghr_pkg.sv */
package ghr_pkg;

    // Fixed-point format of the state variables and of the gain/coupling operands.
    localparam int FRAC_BITS = 32;
    localparam int COEF_FRAC = 32;
    localparam int QW        = 48;
    localparam int NV        = 8;

    typedef logic signed [QW-1:0] t_q;
    typedef t_q [NV-1:0] t_vec;

    // Everything an item carries down the pipeline besides the current operand vector.
    typedef struct packed {
        t_vec        s;
        t_vec        k1;
        t_vec        k2;
        t_vec        k3;
        logic [31:0] w_cp;
        logic [35:0] gain;
        t_q          target;
    } t_ctx;

    localparam logic signed [63:0] Q_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN64 = -64'sh0000_8000_0000_0000;
    localparam t_q Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(QW-1){1'b0}}};

    // Clamp a 64-bit value to the 48-bit range.
    function automatic t_q sat64(input logic signed [63:0] v);
        t_q r;
        if (v > Q_MAX64) begin
            r = Q_MAX;
        end else if (v < Q_MIN64) begin
            r = Q_MIN;
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    // Clamp a sum that has grown by one bit.
    function automatic t_q sat49(input logic signed [QW:0] v);
        t_q r;
        if (v[QW] != v[QW-1]) begin
            r = v[QW] ? Q_MIN : Q_MAX;
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    function automatic t_q add_sat(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        return sat49(s);
    endfunction

    function automatic t_q sub_sat(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} - {b[QW-1], b};
        return sat49(s);
    endfunction

    // Multiply by ten as 8v + 2v, then clamp.
    function automatic t_q mul10_sat(input t_q v);
        logic signed [QW+3:0] e;
        logic signed [QW+3:0] p;
        t_q r;
        e = {{4{v[QW-1]}}, v};
        p = (e <<< 3) + (e <<< 1);
        if (p[QW+3:QW-1] != {5{p[QW+3]}}) begin
            r = p[QW+3] ? Q_MIN : Q_MAX;
        end else begin
            r = p[QW-1:0];
        end
        return r;
    endfunction

    // Constants of the equations and of the step, in Q.FRAC_BITS.
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
    localparam t_q C28      = sat64(64'sd28 <<< FRAC_BITS);
    localparam t_q C83      = sat64(((64'sd16 <<< FRAC_BITS) + 64'sd3) / 64'sd6);
    localparam t_q DT       = sat64((ONE_Q + 64'sd100) / 64'sd200);
    localparam t_q HALF_DT  = sat64((ONE_Q + 64'sd200) / 64'sd400);
    localparam t_q SIXTH_DT = sat64((ONE_Q + 64'sd600) / 64'sd1200);
    localparam t_q TGT_POS  = sat64(64'sd363 <<< FRAC_BITS);
    localparam t_q TGT_NEG  = sat64(-(64'sd363 <<< FRAC_BITS));

endpackage

/* rtl/gated_hyperchaos_rk4_step_core.sv */
// Four slope units and four offset units run as one pipeline.
// Throughput: one cell per cycle while the output is not stalled.
// A stall on the output freezes every stage together; nothing is lost or repeated.
// Reset is synchronous and active low; it clears only the stage valid bits.
module gated_hyperchaos_rk4_step_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [47:0] i_x_a,
    input  logic signed [47:0] i_y_a,
    input  logic signed [47:0] i_z_a,
    input  logic signed [47:0] i_w_a,
    input  logic signed [47:0] i_x_b,
    input  logic signed [47:0] i_y_b,
    input  logic signed [47:0] i_z_b,
    input  logic signed [47:0] i_w_b,
    input  logic        [31:0] i_coupling,
    input  logic        [35:0] i_gate_gain,
    input  logic signed [47:0] i_gate_net,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_next_x_a,
    output logic signed [47:0] o_next_y_a,
    output logic signed [47:0] o_next_z_a,
    output logic signed [47:0] o_next_w_a,
    output logic signed [47:0] o_next_x_b,
    output logic signed [47:0] o_next_y_b,
    output logic signed [47:0] o_next_z_b,
    output logic signed [47:0] o_next_w_b
);

    logic          en;
    ghr_pkg::t_vec s_in;
    ghr_pkg::t_ctx c_in;
    logic          d1_vld, d2_vld, d3_vld, d4_vld, o1_vld, o2_vld, o3_vld, fin_vld;
    ghr_pkg::t_vec k1, k2, k3, k4, t1, t2, t3, fin_t;
    ghr_pkg::t_ctx d1_ctx, d2_ctx, d3_ctx, d4_ctx, c1, c2, c3, o1_ctx, o2_ctx, o3_ctx;
    logic          ra_vld, rb_vld;
    ghr_pkg::t_ctx ra_ctx, rb_ctx;
    ghr_pkg::t_vec n_p, r_p, n_q, r_q, n_acc, r_acc;

    // The whole pipeline advances unless a finished result is held back.
    assign en      = !(fin_vld && i_stall);
    assign o_stall = fin_vld && i_stall;

    // Build the item's context from the input transfer.
    always_comb begin
        s_in        = {i_w_b, i_z_b, i_y_b, i_x_b, i_w_a, i_z_a, i_y_a, i_x_a};
        c_in        = '0;
        c_in.s      = s_in;
        c_in.w_cp   = i_coupling;
        c_in.gain   = i_gate_gain;
        c_in.target = i_gate_net[47] ? ghr_pkg::TGT_NEG : ghr_pkg::TGT_POS;
    end

    // First slope, then the half-step probe.
    ghr_deriv u_d1 (.i_clk, .i_rst_n, .i_en(en), .i_vld(i_valid), .i_t(s_in), .i_ctx(c_in),
                    .o_vld(d1_vld), .o_d(k1), .o_ctx(d1_ctx));

    always_comb begin
        c1    = d1_ctx;
        c1.k1 = k1;
    end

    ghr_offs u_o1 (.i_clk, .i_rst_n, .i_en(en), .i_vld(d1_vld), .i_ctx(c1), .i_k(k1),
                   .i_h(ghr_pkg::HALF_DT), .o_vld(o1_vld), .o_t(t1), .o_ctx(o1_ctx));

    // Second slope.
    ghr_deriv u_d2 (.i_clk, .i_rst_n, .i_en(en), .i_vld(o1_vld), .i_t(t1), .i_ctx(o1_ctx),
                    .o_vld(d2_vld), .o_d(k2), .o_ctx(d2_ctx));

    always_comb begin
        c2    = d2_ctx;
        c2.k2 = k2;
    end

    ghr_offs u_o2 (.i_clk, .i_rst_n, .i_en(en), .i_vld(d2_vld), .i_ctx(c2), .i_k(k2),
                   .i_h(ghr_pkg::HALF_DT), .o_vld(o2_vld), .o_t(t2), .o_ctx(o2_ctx));

    // Third slope, then the full-step probe.
    ghr_deriv u_d3 (.i_clk, .i_rst_n, .i_en(en), .i_vld(o2_vld), .i_t(t2), .i_ctx(o2_ctx),
                    .o_vld(d3_vld), .o_d(k3), .o_ctx(d3_ctx));

    always_comb begin
        c3    = d3_ctx;
        c3.k3 = k3;
    end

    ghr_offs u_o3 (.i_clk, .i_rst_n, .i_en(en), .i_vld(d3_vld), .i_ctx(c3), .i_k(k3),
                   .i_h(ghr_pkg::DT), .o_vld(o3_vld), .o_t(t3), .o_ctx(o3_ctx));

    // Fourth slope.
    ghr_deriv u_d4 (.i_clk, .i_rst_n, .i_en(en), .i_vld(o3_vld), .i_t(t3), .i_ctx(o3_ctx),
                    .o_vld(d4_vld), .o_d(k4), .o_ctx(d4_ctx));

    // Weighted slope sum in two stages: 2*k3 + k4 and 2*k2 first, then the rest.
    always_comb begin
        for (int i = 0; i < ghr_pkg::NV; i++) begin
            n_p[i]   = ghr_pkg::add_sat(ghr_pkg::add_sat(d4_ctx.k3[i], d4_ctx.k3[i]), k4[i]);
            n_q[i]   = ghr_pkg::add_sat(d4_ctx.k2[i], d4_ctx.k2[i]);
            n_acc[i] = ghr_pkg::add_sat(rb_ctx.k1[i], ghr_pkg::add_sat(r_q[i], r_p[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_vld <= 1'b0;
            ra_vld <= 1'b0;
        end else if (en) begin
            rb_vld <= d4_vld;
            ra_vld <= rb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p    <= n_p;
            r_q    <= n_q;
            rb_ctx <= d4_ctx;
            r_acc  <= n_acc;
            ra_ctx <= rb_ctx;
        end
    end

    // Final update: start values plus one sixth of the step times the slope sum.
    ghr_offs u_fin (.i_clk, .i_rst_n, .i_en(en), .i_vld(ra_vld), .i_ctx(ra_ctx), .i_k(r_acc),
                    .i_h(ghr_pkg::SIXTH_DT), .o_vld(fin_vld), .o_t(fin_t), .o_ctx());

    assign o_valid    = fin_vld;
    assign o_next_x_a = fin_t[0];
    assign o_next_y_a = fin_t[1];
    assign o_next_z_a = fin_t[2];
    assign o_next_w_a = fin_t[3];
    assign o_next_x_b = fin_t[4];
    assign o_next_y_b = fin_t[5];
    assign o_next_z_b = fin_t[6];
    assign o_next_w_b = fin_t[7];

endmodule

/* rtl/ghr_mul.sv */
module ghr_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  ghr_pkg::t_q  i_a,
    input  ghr_pkg::t_q  i_b,
    input  logic         i_coef,
    output ghr_pkg::t_q  o_p
);

    localparam int QW = ghr_pkg::QW;
    localparam int LW = QW / 2;
    localparam int PW = 2 * QW + 1;
    localparam logic signed [PW-1:0] HALF_F = PW'(1) <<< (ghr_pkg::FRAC_BITS - 1);
    localparam logic signed [PW-1:0] HALF_C = PW'(1) <<< (ghr_pkg::COEF_FRAC - 1);

    logic signed [QW+LW:0]   n_lo, r_lo;
    logic signed [QW+LW-1:0] n_hi, r_hi;
    logic signed [PW-1:0]    sum, rnd, shf;
    ghr_pkg::t_q             n_p, r_p;

    // First stage: two partial products over the low and high halves of b.
    assign n_lo = (QW+LW+1)'(i_a) * (QW+LW+1)'($signed({1'b0, i_b[LW-1:0]}));
    assign n_hi = (QW+LW)'(i_a) * (QW+LW)'($signed(i_b[QW-1:LW]));

    // Second stage: combine, round half up, shift down and clamp.
    always_comb begin
        sum = (PW'(r_hi) <<< LW) + PW'(r_lo);
        rnd = sum + (i_coef ? HALF_C : HALF_F);
        shf = i_coef ? (rnd >>> ghr_pkg::COEF_FRAC) : (rnd >>> ghr_pkg::FRAC_BITS);
        if (shf[PW-1:QW-1] != {(PW-QW+1){shf[PW-1]}}) begin
            n_p = shf[PW-1] ? ghr_pkg::Q_MIN : ghr_pkg::Q_MAX;
        end else begin
            n_p = shf[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* rtl/ghr_deriv.sv */
module ghr_deriv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  ghr_pkg::t_vec   i_t,
    input  ghr_pkg::t_ctx   i_ctx,
    output logic            o_vld,
    output ghr_pkg::t_vec   o_d,
    output ghr_pkg::t_ctx   o_ctx
);

    localparam int QW = ghr_pkg::QW;

    ghr_pkg::t_q [1:0] n0_dx, n0_czs;
    ghr_pkg::t_q       n0_tw;
    logic              r0_vld, r1_vld, r2_vld, r3_vld;
    ghr_pkg::t_vec     r0_t, r1_t, r2_t;
    ghr_pkg::t_ctx     r0_ctx, r1_ctx, r2_ctx, r3_ctx;
    ghr_pkg::t_q [1:0] r0_dx, r1_dx, r2_dx, r0_czs;
    ghr_pkg::t_q       r0_tw;
    ghr_pkg::t_q       wq;
    ghr_pkg::t_q       gq;
    ghr_pkg::t_q [1:0] m1, m2, m3, m4, m5, m6;
    ghr_pkg::t_q       m7;
    ghr_pkg::t_vec     n3_d, r3_d;
    ghr_pkg::t_q       dw;

    // Linear terms and multiplier operands.
    always_comb begin
        for (int g = 0; g < 2; g++) begin
            n0_dx[g]  = ghr_pkg::mul10_sat(ghr_pkg::sub_sat(i_t[4*g+1], i_t[4*g]));
            n0_czs[g] = ghr_pkg::sub_sat(ghr_pkg::C28, i_t[4*g+2]);
        end
        n0_tw = ghr_pkg::sub_sat(i_ctx.target, i_t[3]);
    end

    assign wq = {{(QW-32){1'b0}}, r0_ctx.w_cp};
    assign gq = {{(QW-36){1'b0}}, r0_ctx.gain};

    // Products of both oscillators.
    for (genvar g = 0; g < 2; g++) begin : g_osc
        ghr_mul u_m1 (.i_clk, .i_en, .i_a(r0_t[4*g]), .i_b(r0_czs[g]), .i_coef(1'b0),
                      .o_p(m1[g]));
        ghr_mul u_m2 (.i_clk, .i_en, .i_a(wq), .i_b(r0_t[4*g+3]), .i_coef(1'b1),
                      .o_p(m2[g]));
        ghr_mul u_m3 (.i_clk, .i_en, .i_a(r0_t[4*g]), .i_b(r0_t[4*g+1]), .i_coef(1'b0),
                      .o_p(m3[g]));
        ghr_mul u_m4 (.i_clk, .i_en, .i_a(ghr_pkg::C83), .i_b(r0_t[4*g+2]), .i_coef(1'b0),
                      .o_p(m4[g]));
        ghr_mul u_m5 (.i_clk, .i_en, .i_a(r0_t[4*g]), .i_b(r0_t[4*g+2]), .i_coef(1'b0),
                      .o_p(m5[g]));
        ghr_mul u_m6 (.i_clk, .i_en, .i_a(wq), .i_b(r0_t[4*g+1]), .i_coef(1'b1),
                      .o_p(m6[g]));
    end

    // Gate pull on the first oscillator's w.
    ghr_mul u_m7 (.i_clk, .i_en, .i_a(gq), .i_b(r0_tw), .i_coef(1'b1), .o_p(m7));

    // Combine the products into the four slopes of each oscillator.
    always_comb begin
        dw = '0;
        for (int g = 0; g < 2; g++) begin
            n3_d[4*g]   = r2_dx[g];
            n3_d[4*g+1] = ghr_pkg::add_sat(ghr_pkg::sub_sat(m1[g], r2_t[4*g+1]), m2[g]);
            n3_d[4*g+2] = ghr_pkg::sub_sat(m3[g], m4[g]);
            n3_d[4*g+3] = ghr_pkg::sub_sat(ghr_pkg::sub_sat(m5[g], r2_t[4*g+3]), m6[g]);
        end
        if (r2_ctx.gain != '0) begin
            dw      = ghr_pkg::add_sat(n3_d[3], m7);
            n3_d[3] = dw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_t   <= i_t;
            r0_ctx <= i_ctx;
            r0_dx  <= n0_dx;
            r0_czs <= n0_czs;
            r0_tw  <= n0_tw;
            r1_t   <= r0_t;
            r1_ctx <= r0_ctx;
            r1_dx  <= r0_dx;
            r2_t   <= r1_t;
            r2_ctx <= r1_ctx;
            r2_dx  <= r1_dx;
            r3_d   <= n3_d;
            r3_ctx <= r2_ctx;
        end
    end

    assign o_vld = r3_vld;
    assign o_d   = r3_d;
    assign o_ctx = r3_ctx;

endmodule

/* rtl/ghr_offs.sv */
module ghr_offs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  ghr_pkg::t_ctx   i_ctx,
    input  ghr_pkg::t_vec   i_k,
    input  ghr_pkg::t_q     i_h,
    output logic            o_vld,
    output ghr_pkg::t_vec   o_t,
    output ghr_pkg::t_ctx   o_ctx
);

    logic          r1_vld, r2_vld, r3_vld;
    ghr_pkg::t_ctx r1_ctx, r2_ctx, r3_ctx;
    ghr_pkg::t_vec m, n3_t, r3_t;

    // Scale every slope by the step fraction.
    for (genvar i = 0; i < ghr_pkg::NV; i++) begin : g_var
        ghr_mul u_m (.i_clk, .i_en, .i_a(i_h), .i_b(i_k[i]), .i_coef(1'b0), .o_p(m[i]));
    end

    // Add the scaled slopes to the start values.
    always_comb begin
        for (int i = 0; i < ghr_pkg::NV; i++) begin
            n3_t[i] = ghr_pkg::add_sat(r2_ctx.s[i], m[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctx <= i_ctx;
            r2_ctx <= r1_ctx;
            r3_ctx <= r2_ctx;
            r3_t   <= n3_t;
        end
    end

    assign o_vld = r3_vld;
    assign o_t   = r3_t;
    assign o_ctx = r3_ctx;

endmodule

/* rtl/ghr_chk.sv */
module ghr_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_stall,
    input logic               o_valid,
    input logic               o_stall,
    input logic signed [47:0] o_next_x_a
);

    // A held result keeps its value while the output is stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_next_x_a))
        else $error("stalled result changed");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The input side is held back only by a stalled, waiting result.
    a_backp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    // A waiting result that is stalled always holds the input side back.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while result stalled");

endmodule

bind gated_hyperchaos_rk4_step_core ghr_chk u_chk (.*);
